// ===== design/jdbe_pkg.sv =====
// Shared types and constants for the joystick direction and button event block.
// No dependencies; used by the top level and its checker.
`default_nettype none

package jdbe_pkg;

    localparam int unsigned SAMPLE_W    = 12;
    localparam int unsigned THRESH_W    = 11;
    localparam int unsigned DIR_W       = 4;
    localparam int unsigned BTN_LIMIT   = 4;
    localparam int unsigned BTN_IDX_W   = 2;
    localparam int unsigned EV_SLOTS    = 1 + BTN_LIMIT;
    localparam int unsigned EV_IDX_W    = 3;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 11;
    localparam int unsigned IN_DATA_W   = 32;
    localparam int unsigned OUT_DATA_W  = 40;

    typedef enum logic [1:0] {
        EV_DIRECTION = 2'd0,
        EV_PRESS     = 2'd1,
        EV_RELEASE   = 2'd2
    } t_event_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD    = 3'd0,
        REG_INVERT_X     = 3'd1,
        REG_INVERT_Y     = 3'd2,
        REG_BUTTONS_USED = 3'd3,
        REG_ACTIVE_LVLS  = 3'd4
    } t_cfg_reg;

    localparam logic [DIR_W-1:0] DIR_CENTER    = 4'd0;
    localparam logic [DIR_W-1:0] DIR_UP        = 4'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN      = 4'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT      = 4'd3;
    localparam logic [DIR_W-1:0] DIR_RIGHT     = 4'd4;
    localparam logic [DIR_W-1:0] DIR_UPLEFT    = 4'd5;
    localparam logic [DIR_W-1:0] DIR_UPRIGHT   = 4'd6;
    localparam logic [DIR_W-1:0] DIR_DOWNLEFT  = 4'd7;
    localparam logic [DIR_W-1:0] DIR_DOWNRIGHT = 4'd8;

    localparam logic [THRESH_W-1:0]  THRESH_RESET  = 11'd400;
    localparam logic [2:0]           BTN_USED_RST  = 3'd1;

endpackage

`default_nettype wire

// ===== design/joystick_direction_and_button_events.sv =====
// Top level: joystick direction classifier with counter-debounced buttons.
// Depends on jdbe_pkg.
//
// Each accepted slave beat is one poll tick. Direction and debounce state are
// updated in the accepting cycle and the tick's events (a direction change,
// then presses and releases in button order, at most five) are held in a
// pending register and moved one per cycle, while the master side is not
// stalled, into the master output register. The next tick is taken in the
// cycle its predecessor's last event enters the output register, so ticks
// with at most one event flow at one per cycle when the master side does
// not stall. The drain of the pending register sets the rate.
// tdata in:  [11:0] x_sample, [12] x_ok, [24:13] y_sample, [25] y_ok,
//            [29:26] button_pins, rest zero.
// tdata out: [3:0] direction, [5:4] button_index, [17:6] x_value,
//            [29:18] y_value, [33:30] held_buttons, rest zero.
// tuser out: [1:0] event_kind. tlast marks the final event of a tick.
`default_nettype none

module joystick_direction_and_button_events #(
    parameter int unsigned MAX_BUTTONS    = 4,
    parameter int unsigned STABLE_TICKS   = 3,
    parameter int unsigned CENTER_VALUE   = 2048,
    parameter int unsigned SAMPLE_BITS    = 12
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [jdbe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [jdbe_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // slave side
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [jdbe_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // x_sample, x_ok, y_sample, y_ok, button_pins
    // master side
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [jdbe_pkg::OUT_DATA_W-1:0]        m_axis_tdata,   // direction, button_index, x_value, y_value, held_buttons
    output logic [1:0]                             m_axis_tuser,   // event_kind
    output logic                                   m_axis_tlast
);

    localparam int unsigned NB = (MAX_BUTTONS < jdbe_pkg::BTN_LIMIT) ?
                                 MAX_BUTTONS : jdbe_pkg::BTN_LIMIT;
    localparam int unsigned CW = $clog2(STABLE_TICKS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(STABLE_TICKS);
    localparam logic [jdbe_pkg::SAMPLE_W-1:0] SMASK =
        jdbe_pkg::SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [jdbe_pkg::SAMPLE_W-1:0] CENTER_U = jdbe_pkg::SAMPLE_W'(CENTER_VALUE);
    localparam logic signed [13:0] CENTER_S = 14'(CENTER_VALUE);
    localparam logic [2:0] NB_U = 3'(NB);

    // configuration registers
    logic [jdbe_pkg::THRESH_W-1:0] r_threshold;
    logic                          r_invert_x;
    logic                          r_invert_y;
    logic [2:0]                    r_buttons_used;
    logic [3:0]                    r_active_levels;

    // tracking state
    logic [jdbe_pkg::DIR_W-1:0]    r_prev_dir;
    logic [CW-1:0]                 r_cnt    [NB];
    logic [NB-1:0]                 r_stable;

    // pending events of the last accepted tick
    logic [jdbe_pkg::EV_SLOTS-1:0] r_pend;
    logic [jdbe_pkg::BTN_LIMIT-1:0] r_pend_press;
    logic [jdbe_pkg::DIR_W-1:0]    r_pend_dir;
    logic [jdbe_pkg::SAMPLE_W-1:0] r_pend_x;
    logic [jdbe_pkg::SAMPLE_W-1:0] r_pend_y;
    logic [3:0]                    r_pend_held;

    // output register
    logic                          r_o_valid;
    jdbe_pkg::t_event_kind         r_o_kind;
    logic [jdbe_pkg::DIR_W-1:0]    r_o_dir;
    logic [jdbe_pkg::BTN_IDX_W-1:0] r_o_idx;
    logic [jdbe_pkg::SAMPLE_W-1:0] r_o_x;
    logic [jdbe_pkg::SAMPLE_W-1:0] r_o_y;
    logic [3:0]                    r_o_held;
    logic                          r_o_last;

    logic                          in_accept;
    logic                          out_load;
    logic [jdbe_pkg::SAMPLE_W-1:0] x_val;
    logic [jdbe_pkg::SAMPLE_W-1:0] y_val;
    logic [3:0]                    pins;
    logic signed [13:0]            rx;
    logic signed [13:0]            ry;
    logic signed [13:0]            thr_s;
    logic                          go_up, go_down, go_left, go_right;
    logic [jdbe_pkg::DIR_W-1:0]    dir;
    logic [2:0]                    used;
    logic [CW-1:0]                 n_cnt    [NB];
    logic [NB-1:0]                 n_stable;
    logic [jdbe_pkg::BTN_LIMIT-1:0] ev_btn;
    logic [jdbe_pkg::BTN_LIMIT-1:0] ev_press;
    logic [3:0]                    held;
    logic [jdbe_pkg::EV_IDX_W-1:0] sel;
    logic [jdbe_pkg::BTN_IDX_W-1:0] sel_btn;
    logic [jdbe_pkg::EV_SLOTS-1:0] pend_rest;

    assign o_cfg_ready = 1'b1;

    // slave side decode
    always_comb begin
        x_val = s_axis_tdata[12] ? (s_axis_tdata[11:0] & SMASK) : CENTER_U;
        y_val = s_axis_tdata[25] ? (s_axis_tdata[24:13] & SMASK) : CENTER_U;
        pins  = s_axis_tdata[29:26];
    end

    // direction classification
    always_comb begin
        rx = $signed({2'b00, x_val}) - CENTER_S;
        ry = CENTER_S - $signed({2'b00, y_val});
        if (r_invert_x) begin
            rx = -rx;
        end
        if (r_invert_y) begin
            ry = -ry;
        end
        thr_s    = $signed({3'b000, r_threshold});
        go_right = rx > thr_s;
        go_left  = rx < -thr_s;
        go_up    = ry > thr_s;
        go_down  = ry < -thr_s;
        if (go_up && go_right) begin
            dir = jdbe_pkg::DIR_UPRIGHT;
        end else if (go_up && go_left) begin
            dir = jdbe_pkg::DIR_UPLEFT;
        end else if (go_down && go_right) begin
            dir = jdbe_pkg::DIR_DOWNRIGHT;
        end else if (go_down && go_left) begin
            dir = jdbe_pkg::DIR_DOWNLEFT;
        end else if (go_up) begin
            dir = jdbe_pkg::DIR_UP;
        end else if (go_down) begin
            dir = jdbe_pkg::DIR_DOWN;
        end else if (go_right) begin
            dir = jdbe_pkg::DIR_RIGHT;
        end else if (go_left) begin
            dir = jdbe_pkg::DIR_LEFT;
        end else begin
            dir = jdbe_pkg::DIR_CENTER;
        end
    end

    // debounce
    always_comb begin
        used     = (r_buttons_used > NB_U) ? NB_U : r_buttons_used;
        ev_btn   = '0;
        ev_press = '0;
        for (int i = 0; i < NB; i++) begin
            n_cnt[i]    = r_cnt[i];
            n_stable[i] = r_stable[i];
            if (3'(i) < used) begin
                if (pins[i] == r_active_levels[i]) begin
                    if (r_cnt[i] != CNT_MAX) begin
                        n_cnt[i] = r_cnt[i] + CW'(1);
                    end
                end else if (r_cnt[i] != '0) begin
                    n_cnt[i] = r_cnt[i] - CW'(1);
                end
                if (!r_stable[i] && n_cnt[i] == CNT_MAX) begin
                    n_stable[i] = 1'b1;
                    ev_btn[i]   = 1'b1;
                    ev_press[i] = 1'b1;
                end else if (r_stable[i] && n_cnt[i] == '0) begin
                    n_stable[i] = 1'b0;
                    ev_btn[i]   = 1'b1;
                end
            end
        end
    end

    for (genvar g = 0; g < jdbe_pkg::BTN_LIMIT; g++) begin : g_held
        if (g < NB) begin : g_on
            assign held[g] = n_stable[g];
        end else begin : g_off
            assign held[g] = 1'b0;
        end
    end

    // pick the lowest pending event
    always_comb begin
        sel = '0;
        for (int i = jdbe_pkg::EV_SLOTS - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                sel = jdbe_pkg::EV_IDX_W'(i);
            end
        end
        pend_rest      = r_pend;
        pend_rest[sel] = 1'b0;
        sel_btn        = jdbe_pkg::BTN_IDX_W'(sel - 3'd1);
    end

    assign out_load      = (r_pend != '0) && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = (r_pend == '0) || (out_load && pend_rest == '0);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold     <= jdbe_pkg::THRESH_RESET;
            r_invert_x      <= 1'b0;
            r_invert_y      <= 1'b0;
            r_buttons_used  <= jdbe_pkg::BTN_USED_RST;
            r_active_levels <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                jdbe_pkg::REG_THRESHOLD:    r_threshold     <= i_cfg_data;
                jdbe_pkg::REG_INVERT_X:     r_invert_x      <= i_cfg_data[0];
                jdbe_pkg::REG_INVERT_Y:     r_invert_y      <= i_cfg_data[0];
                jdbe_pkg::REG_BUTTONS_USED: r_buttons_used  <= i_cfg_data[2:0];
                jdbe_pkg::REG_ACTIVE_LVLS:  r_active_levels <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_dir <= jdbe_pkg::DIR_CENTER;
            r_stable   <= '0;
            for (int i = 0; i < NB; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (in_accept) begin
            r_prev_dir <= dir;
            r_stable   <= n_stable;
            for (int i = 0; i < NB; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (in_accept) begin
            r_pend <= {ev_btn, dir != r_prev_dir};
        end else if (out_load) begin
            r_pend <= pend_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pend_press <= ev_press;
            r_pend_dir   <= dir;
            r_pend_x     <= x_val;
            r_pend_y     <= y_val;
            r_pend_held  <= held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (sel == '0) begin
                r_o_kind <= jdbe_pkg::EV_DIRECTION;
                r_o_idx  <= '0;
            end else begin
                r_o_kind <= r_pend_press[sel_btn] ? jdbe_pkg::EV_PRESS
                                                  : jdbe_pkg::EV_RELEASE;
                r_o_idx  <= sel_btn;
            end
            r_o_dir  <= r_pend_dir;
            r_o_x    <= r_pend_x;
            r_o_y    <= r_pend_y;
            r_o_held <= r_pend_held;
            r_o_last <= (pend_rest == '0);
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {6'd0, r_o_held, r_o_y, r_o_x, r_o_idx, r_o_dir};

endmodule

`default_nettype wire

// ===== design/jdbe_checker.sv =====
// Port-level checker for the joystick direction and button event block.
// Depends on jdbe_pkg; bound to the top level below.
`default_nettype none

module jdbe_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    a_hold_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("master beat dropped while stalled");

    a_kind_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == jdbe_pkg::EV_DIRECTION ||
                           m_axis_tuser == jdbe_pkg::EV_PRESS ||
                           m_axis_tuser == jdbe_pkg::EV_RELEASE))
        else $error("undefined event kind");

    a_dir_index : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == jdbe_pkg::EV_DIRECTION |->
            m_axis_tdata[5:4] == 2'd0)
        else $error("direction beat carries a button index");

    a_press_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == jdbe_pkg::EV_PRESS && m_axis_tlast |->
            m_axis_tdata[30 + m_axis_tdata[5:4]])
        else $error("pressed button not shown as held");

    a_dir_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= jdbe_pkg::DIR_DOWNRIGHT)
        else $error("direction code out of range");

endmodule

bind joystick_direction_and_button_events jdbe_checker u_jdbe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
